// ===== src/buck_boost_dead_time_sequencer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Buck-boost dead-time sequencer assertion macros
// Shared property wrappers, sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUCK_BOOST_DEAD_TIME_SEQUENCER_CORE_ASSERT_SVH
`define BUCK_BOOST_DEAD_TIME_SEQUENCER_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define BBDT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbdt assertion failed");

// The consequent holds in the cycle after the antecedent.
`define BBDT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbdt assertion failed");

`endif

// ===== src/bbdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Buck-boost dead-time sequencer package
// Mode codes, gate bit masks, reset values and shared state types.
// ----------------------------------------------------------------------------
package bbdt_pkg;

	typedef enum logic [2:0] {
		MODE_ALL_OFF    = 3'd0,
		MODE_BUCK_OFF   = 3'd1,
		MODE_BUCK_SOFT  = 3'd2,
		MODE_BUCK_ON    = 3'd3,
		MODE_BOOST_OFF  = 3'd4,
		MODE_BOOST_SOFT = 3'd5,
		MODE_BOOST_ON   = 3'd6,
		MODE_DISCHARGE  = 3'd7
	} mode_t;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_REQUEST = 1'b1
	} opcode_t;

	localparam logic [3:0] G_BUCK_L  = 4'h1;
	localparam logic [3:0] G_BUCK_H  = 4'h2;
	localparam logic [3:0] G_BOOST_L = 4'h4;
	localparam logic [3:0] G_BOOST_H = 4'h8;

	localparam logic [3:0] PAT_BUCK_OFF  = 4'h9;
	localparam logic [3:0] PAT_BUCK_ON   = 4'hA;
	localparam logic [3:0] PAT_BOOST_OFF = 4'hA;
	localparam logic [3:0] PAT_BOOST_ON  = 4'h6;
	localparam logic [3:0] PAT_DISCHARGE = 4'h5;

	localparam logic [15:0] DEAD_TIME_RESET  = 16'd100;
	localparam logic [15:0] SOFT_DELAY_RESET = 16'd700;

	localparam int unsigned CFG_ADDR_W = 3;

	typedef struct packed {
		logic [15:0] dead_time_ticks;
		logic [15:0] soft_delay_ticks;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  gate_bits;
		mode_t       mode;
		logic [15:0] countdown;
		logic        armed;
	} state_t;

	// Break before make in one half bridge: clear the opposite switch if it
	// is on, otherwise turn the target switch on.
	function automatic logic [3:0] half_bridge(logic [3:0] g, logic [3:0] opp,
			logic [3:0] tgt);
		return (|(g & opp)) ? (g & ~opp) : (g | tgt);
	endfunction

endpackage

// ===== src/bbdt_cfg.sv =====
// ----------------------------------------------------------------------------
// Buck-boost dead-time sequencer configuration registers
// APB-style register file holding the dead-time and soft-delay tick counts.
// ----------------------------------------------------------------------------
module bbdt_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bbdt_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output bbdt_pkg::cfg_t                   cfg
);

	bbdt_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_time_ticks  <= bbdt_pkg::DEAD_TIME_RESET;
			cfg_q.soft_delay_ticks <= bbdt_pkg::SOFT_DELAY_RESET;
		end else if (wr_en) begin
			if (paddr[2]) begin
				cfg_q.soft_delay_ticks <= pwdata[15:0];
			end else begin
				cfg_q.dead_time_ticks <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		if (paddr[2]) begin
			prdata = {16'd0, cfg_q.soft_delay_ticks};
		end else begin
			prdata = {16'd0, cfg_q.dead_time_ticks};
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/bbdt_step.sv =====
// ----------------------------------------------------------------------------
// Buck-boost dead-time sequencer step logic
// Computes the next gate pattern, mode and countdown for one transaction.
// ----------------------------------------------------------------------------
module bbdt_step (
	input  bbdt_pkg::cfg_t    cfg,
	input  bbdt_pkg::state_t  cur,
	input  bbdt_pkg::opcode_t opcode,
	input  bbdt_pkg::mode_t   req,
	output bbdt_pkg::state_t  nxt
);

	logic [3:0] g_req;
	logic [3:0] g_exp;

	always_comb begin
		unique case (req) inside
			bbdt_pkg::MODE_BUCK_OFF: begin
				g_req = bbdt_pkg::half_bridge(cur.gate_bits, bbdt_pkg::G_BUCK_H,
					bbdt_pkg::G_BUCK_L);
				g_req = bbdt_pkg::half_bridge(g_req, bbdt_pkg::G_BOOST_L,
					bbdt_pkg::G_BOOST_H);
			end
			bbdt_pkg::MODE_BUCK_SOFT: begin
				g_req = cur.gate_bits & ~(bbdt_pkg::G_BUCK_L | bbdt_pkg::G_BUCK_H);
				g_req = bbdt_pkg::half_bridge(g_req, bbdt_pkg::G_BOOST_L,
					bbdt_pkg::G_BOOST_H);
			end
			bbdt_pkg::MODE_BUCK_ON, bbdt_pkg::MODE_BOOST_OFF: begin
				g_req = bbdt_pkg::half_bridge(cur.gate_bits, bbdt_pkg::G_BUCK_L,
					bbdt_pkg::G_BUCK_H);
				g_req = bbdt_pkg::half_bridge(g_req, bbdt_pkg::G_BOOST_L,
					bbdt_pkg::G_BOOST_H);
			end
			bbdt_pkg::MODE_BOOST_SOFT: begin
				g_req = bbdt_pkg::half_bridge(cur.gate_bits, bbdt_pkg::G_BUCK_L,
					bbdt_pkg::G_BUCK_H);
				g_req = g_req & ~(bbdt_pkg::G_BOOST_L | bbdt_pkg::G_BOOST_H);
			end
			bbdt_pkg::MODE_BOOST_ON: begin
				g_req = bbdt_pkg::half_bridge(cur.gate_bits, bbdt_pkg::G_BUCK_L,
					bbdt_pkg::G_BUCK_H);
				g_req = bbdt_pkg::half_bridge(g_req, bbdt_pkg::G_BOOST_H,
					bbdt_pkg::G_BOOST_L);
			end
			bbdt_pkg::MODE_DISCHARGE: begin
				g_req = bbdt_pkg::half_bridge(cur.gate_bits, bbdt_pkg::G_BUCK_H,
					bbdt_pkg::G_BUCK_L);
				g_req = bbdt_pkg::half_bridge(g_req, bbdt_pkg::G_BOOST_H,
					bbdt_pkg::G_BOOST_L);
			end
			default: begin
				g_req = 4'h0;
			end
		endcase
	end

	always_comb begin
		unique case (cur.mode) inside
			bbdt_pkg::MODE_BUCK_OFF:   g_exp = cur.gate_bits | bbdt_pkg::PAT_BUCK_OFF;
			bbdt_pkg::MODE_BUCK_SOFT:  g_exp = (cur.gate_bits & ~bbdt_pkg::G_BUCK_L) |
				bbdt_pkg::G_BOOST_H;
			bbdt_pkg::MODE_BUCK_ON:    g_exp = cur.gate_bits | bbdt_pkg::PAT_BUCK_ON;
			bbdt_pkg::MODE_BOOST_OFF:  g_exp = cur.gate_bits | bbdt_pkg::PAT_BOOST_OFF;
			bbdt_pkg::MODE_BOOST_SOFT: g_exp = (cur.gate_bits & ~bbdt_pkg::G_BOOST_H) |
				bbdt_pkg::G_BUCK_H;
			bbdt_pkg::MODE_BOOST_ON:   g_exp = cur.gate_bits | bbdt_pkg::PAT_BOOST_ON;
			bbdt_pkg::MODE_DISCHARGE:  g_exp = cur.gate_bits | bbdt_pkg::PAT_DISCHARGE;
			default:                   g_exp = cur.gate_bits;
		endcase
	end

	always_comb begin
		nxt = cur;
		if (opcode == bbdt_pkg::OP_REQUEST) begin
			nxt.gate_bits = g_req;
			if (req != cur.mode) begin
				nxt.countdown = cfg.dead_time_ticks;
				nxt.armed     = 1'b1;
				nxt.mode      = req;
			end
		end else if (cur.armed) begin
			if (cur.countdown <= 16'd1) begin
				// Expiry: OFF modes chain into their soft countdown.
				nxt.gate_bits = g_exp;
				nxt.countdown = 16'd0;
				nxt.armed     = 1'b0;
				if (cur.mode == bbdt_pkg::MODE_BUCK_OFF) begin
					nxt.countdown = cfg.soft_delay_ticks;
					nxt.armed     = 1'b1;
					nxt.mode      = bbdt_pkg::MODE_BUCK_SOFT;
				end else if (cur.mode == bbdt_pkg::MODE_BOOST_OFF) begin
					nxt.countdown = cfg.soft_delay_ticks;
					nxt.armed     = 1'b1;
					nxt.mode      = bbdt_pkg::MODE_BOOST_SOFT;
				end
			end else begin
				nxt.countdown = cur.countdown - 16'd1;
			end
		end
	end

endmodule

// ===== src/buck_boost_dead_time_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// Buck-boost dead-time sequencer core
// Gate sequencer for a four-switch buck-boost stage with dead-time timing.
// ----------------------------------------------------------------------------
// The core takes one transaction per clock while the output is not stalled,
// either a timer tick or a mode request, and returns exactly one result
// transaction for each: the gate pattern, the active mode and a busy flag
// for the pending countdown. An accepted transaction is held in the input
// register, and its result is written to the output register once that
// register is empty or its result is being taken. The sustained rate is one
// transaction per cycle while m_tready stays high. The input side keeps
// accepting while a result waits in the output register as long as the
// input register drains into it.
`include "buck_boost_dead_time_sequencer_core_assert.svh"

module buck_boost_dead_time_sequencer_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [2:0] requested_mode
	input  logic                             s_tuser,  // [0] opcode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,  // [3:0] gate_drive, [6:4] active_mode,
	                                                   // [7] timer_busy
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bbdt_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	bbdt_pkg::cfg_t    cfg;
	bbdt_pkg::state_t  state_q;
	bbdt_pkg::state_t  state_nxt;
	logic              valid_s1;
	bbdt_pkg::opcode_t opcode_s1;
	bbdt_pkg::mode_t   req_s1;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;
	logic              advance;
	logic              in_xfer;

	bbdt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bbdt_step u_step (
		.cfg    (cfg),
		.cur    (state_q),
		.opcode (opcode_s1),
		.req    (req_s1),
		.nxt    (state_nxt)
	);

	assign advance  = valid_s1 & (~m_tvalid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign in_xfer  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_s1 <= bbdt_pkg::opcode_t'(s_tuser);
			req_s1    <= bbdt_pkg::mode_t'(s_tdata[2:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.gate_bits <= 4'h0;
			state_q.mode      <= bbdt_pkg::MODE_ALL_OFF;
			state_q.countdown <= 16'd0;
			state_q.armed     <= 1'b0;
			m_tvalid_q        <= 1'b0;
		end else begin
			if (advance) begin
				state_q    <= state_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {state_nxt.armed, state_nxt.mode, state_nxt.gate_bits};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`BBDT_ASSERT_SAME(a_idle_timer_clear, !state_q.armed, state_q.countdown == 16'd0)
	`BBDT_ASSERT_SAME(a_ready_when_out_free, !m_tvalid_q, s_tready)
	`BBDT_ASSERT_NEXT(a_result_busy_matches, advance, m_tdata_q[7] == state_q.armed)
	`BBDT_ASSERT_NEXT(a_result_mode_matches, advance, m_tdata_q[6:4] == state_q.mode)

endmodule
